### rtl/core/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the frame store RTL; empty under synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define RFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define RFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFB_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/rfb_pkg.sv
// ============================================================================
// rfb_pkg
// Types and constants of the RGB frame store and its drawing engine.
// ============================================================================
package rfb_pkg;

    localparam int COLOR_W    = 24;
    localparam int OPCODE_W   = 3;
    localparam int POS_W      = 8;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    // signed pixel coordinate; wide enough for any clipped edge and canvas size
    localparam int COORD_W    = 14;

    localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] CANVAS_RESET = 9'd256;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_POINT   = 3'd1,
        OP_READ    = 3'd2,
        OP_OUTLINE = 3'd3,
        OP_FILL    = 3'd4
    } op_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // one pixel access from the sequencer to the pixel unit and the store
    typedef struct packed {
        logic               wr;
        logic               rd;
        coord_t             x;
        coord_t             y;
        logic [COLOR_W-1:0] color;
    } pix_req_t;

endpackage

### rtl/core/rfb_cmd_if.sv
// ============================================================================
// rfb_cmd_if
// Command channel: one drawing or read command per word.
// ============================================================================
interface rfb_cmd_if
    import rfb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [SIZE_W-1:0]   rect_width;
    logic [SIZE_W-1:0]   rect_height;
    logic [COLOR_W-1:0]  draw_color;

    modport source (
        output valid, opcode, pos_x, pos_y, rect_width, rect_height, draw_color,
        input  ready
    );
    modport sink (
        input  valid, opcode, pos_x, pos_y, rect_width, rect_height, draw_color,
        output ready
    );
endinterface

### rtl/core/rfb_rsp_if.sv
// ============================================================================
// rfb_rsp_if
// Result channel: one color word per command.
// ============================================================================
interface rfb_rsp_if
    import rfb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] read_color;

    modport source (
        output valid, read_color,
        input  ready
    );
    modport sink (
        input  valid, read_color,
        output ready
    );
endinterface

### rtl/core/rfb_store.sv
// ============================================================================
// rfb_store
// Single-port pixel memory with registered read data.
// ============================================================================
module rfb_store
    import rfb_pkg::*;
#(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      addr,
    input  logic [COLOR_W-1:0] wdata,
    output logic [COLOR_W-1:0] rdata
);

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rfb_pix.sv
// ============================================================================
// rfb_pix
// Shared pixel unit: clip a coordinate to the canvas and form the address.
// ============================================================================
module rfb_pix
    import rfb_pkg::*;
#(
    parameter int XW = 8,
    parameter int YW = 8
) (
    input  pix_req_t         req,
    input  coord_t           eff_w,
    input  coord_t           eff_h,
    output logic             hit,
    output logic             we,
    output logic [XW+YW-1:0] addr
);

    coord_t row;

    // rows are stored bottom-up
    assign row  = eff_h - req.y - coord_t'(1);
    assign hit  = (req.x >= 0) && (req.x < eff_w) && (req.y >= 0) && (req.y < eff_h);
    assign we   = req.wr && hit;
    assign addr = {row[YW-1:0], req.x[XW-1:0]};

endmodule

### rtl/core/rfb_seq.sv
// ============================================================================
// rfb_seq
// Command sequencer: walks clear sweeps, points, reads, outline edges and
// fill rows one pixel per cycle, and holds the result word.
// ============================================================================
`include "assert_macros.svh"

module rfb_seq
    import rfb_pkg::*;
#(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    rfb_cmd_if.sink            cmd,
    rfb_rsp_if.source          rsp,
    input  coord_t             eff_w,
    input  coord_t             eff_h,
    input  logic               pix_hit,
    input  logic [COLOR_W-1:0] rd_data,
    output pix_req_t           req,
    output logic               clr_we,
    output logic [AW-1:0]      clr_addr
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_CLEAR   = 8'b0000_0010,
        ST_POINT   = 8'b0000_0100,
        ST_READ    = 8'b0000_1000,
        ST_RDWAIT  = 8'b0001_0000,
        ST_OUTLINE = 8'b0010_0000,
        ST_FILL    = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   x_reg, x_next;
    logic [POS_W-1:0]   y_reg, y_next;
    logic [SIZE_W-1:0]  w_reg, w_next;
    logic [SIZE_W-1:0]  h_reg, h_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    coord_t             cur_x_reg, cur_x_next;
    coord_t             cur_y_reg, cur_y_next;
    logic [SIZE_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0]  rows_reg, rows_next;
    logic [1:0]         phase_reg, phase_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic               boot_reg, boot_next;
    logic               hit_reg, hit_next;
    logic [COLOR_W-1:0] result_reg, result_next;
    logic               out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;

    logic accept;
    logic fits;

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign accept         = cmd.valid && cmd.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_color = out_color_reg;
    assign clr_addr       = sweep_reg;

    // the whole rectangle must fit before outline or fill draws anything
    assign fits = (coord_t'(cmd.pos_x) + coord_t'(cmd.rect_width) <= eff_w) &&
                  (coord_t'(cmd.pos_y) + coord_t'(cmd.rect_height) <= eff_h);

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        color_next     = color_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cnt_next       = cnt_reg;
        rows_next      = rows_reg;
        phase_next     = phase_reg;
        sweep_next     = sweep_reg;
        boot_next      = boot_reg;
        hit_next       = hit_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_color_next = out_color_reg;
        clr_we         = 1'b0;
        req.wr         = 1'b0;
        req.rd         = 1'b0;
        req.x          = cur_x_reg;
        req.y          = cur_y_reg;
        req.color      = color_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next      = cmd.pos_x;
                    y_next      = cmd.pos_y;
                    w_next      = cmd.rect_width;
                    h_next      = cmd.rect_height;
                    color_next  = cmd.draw_color;
                    cur_x_next  = coord_t'(cmd.pos_x);
                    cur_y_next  = coord_t'(cmd.pos_y);
                    cnt_next    = cmd.rect_width;
                    rows_next   = cmd.rect_height;
                    phase_next  = 2'd0;
                    result_next = '0;
                    case (op_t'(cmd.opcode))
                        OP_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_POINT:   state_next = ST_POINT;
                        OP_READ:    state_next = ST_READ;
                        OP_OUTLINE: state_next = fits ? ST_OUTLINE : ST_FINISH;
                        OP_FILL:
                        begin
                            state_next = (fits && (cmd.rect_height != '0)) ? ST_FILL
                                                                           : ST_FINISH;
                        end
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end

            ST_CLEAR:
            begin
                clr_we = 1'b1;
                if (sweep_reg == SWEEP_LAST)
                begin
                    // the pass after reset gives no result word
                    state_next = boot_reg ? ST_IDLE : ST_FINISH;
                    boot_next  = 1'b0;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            ST_POINT:
            begin
                req.wr     = 1'b1;
                state_next = ST_FINISH;
            end

            ST_READ:
            begin
                req.rd     = 1'b1;
                hit_next   = pix_hit;
                state_next = ST_RDWAIT;
            end

            ST_RDWAIT:
            begin
                result_next = hit_reg ? rd_data : '0;
                state_next  = ST_FINISH;
            end

            ST_OUTLINE:
            begin
                if (cnt_reg != '0)
                begin
                    req.wr   = 1'b1;
                    cnt_next = cnt_reg - SIZE_W'(1);
                    if (!phase_reg[1])
                    begin
                        cur_x_next = cur_x_reg + coord_t'(1);
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + coord_t'(1);
                    end
                end
                else
                begin
                    // set up the next edge: bottom row, left column, right column
                    case (phase_reg)
                        2'd0:
                        begin
                            cur_x_next = coord_t'(x_reg);
                            cur_y_next = coord_t'(y_reg) + coord_t'(h_reg) - coord_t'(1);
                            cnt_next   = w_reg;
                            phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            cur_x_next = coord_t'(x_reg);
                            cur_y_next = coord_t'(y_reg);
                            cnt_next   = h_reg;
                            phase_next = 2'd2;
                        end
                        2'd2:
                        begin
                            cur_x_next = coord_t'(x_reg) + coord_t'(w_reg) - coord_t'(1);
                            cur_y_next = coord_t'(y_reg);
                            cnt_next   = h_reg;
                            phase_next = 2'd3;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_FILL:
            begin
                if (cnt_reg != '0)
                begin
                    req.wr     = 1'b1;
                    cnt_next   = cnt_reg - SIZE_W'(1);
                    cur_x_next = cur_x_reg + coord_t'(1);
                end
                else if (rows_reg == SIZE_W'(1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    rows_next  = rows_reg - SIZE_W'(1);
                    cur_y_next = cur_y_reg + coord_t'(1);
                    cur_x_next = coord_t'(x_reg);
                    cnt_next   = w_reg;
                end
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        color_reg     <= color_next;
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        cnt_reg       <= cnt_next;
        rows_reg      <= rows_next;
        phase_reg     <= phase_next;
        hit_reg       <= hit_next;
        result_reg    <= result_next;
        out_color_reg <= out_color_next;
    end

    `RFB_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> !cmd.ready, "ready high after accept")
    `RFB_ASSERT(a_finish_holds, clk, rst_n, (state_reg == ST_FINISH && out_valid_reg && !rsp.ready) |=> (state_reg == ST_FINISH), "result dropped while output full")
    `RFB_ASSERT(a_sweep_in_range, clk, rst_n, (state_reg == ST_CLEAR) |-> (sweep_reg <= SWEEP_LAST), "clear sweep past store end")

endmodule

### rtl/core/rgb_framebuffer_rect_draw.sv
// ============================================================================
// rgb_framebuffer_rect_draw
// 24-bit RGB frame store with a clear / point / read / outline / fill engine.
// ============================================================================
// Each command word yields exactly one result word; read_color carries the
// pixel for a read inside the canvas and 0 otherwise. The engine handles one
// command at a time and writes at most one pixel per cycle through a single
// memory port: a point write passes a write state, then a finish state that
// registers its result before idle takes the next word; a read adds a wait
// state for the registered memory output. A fill walks each row of pixels
// with a row step after it, an outline its top, bottom, left and right edges
// with a setup after each, and a clear sweeps all MAX_HEIGHT*2**ceil(log2(MAX_WIDTH))
// words of the store (65536 at the default size); each command ends in the
// finish state. An outline or fill that does not fit, or a fill of zero
// height, goes straight there. After reset the same sweep paints the store
// white before the first command is taken; configuration writes are accepted throughout.
// ============================================================================
`include "assert_macros.svh"

module rgb_framebuffer_rect_draw
    import rfb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rfb_cmd_if.sink               cmd,
    rfb_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // column bits and row bits of the store address
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = MAX_HEIGHT * (2 ** XW);

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    coord_t             eff_w;
    coord_t             eff_h;

    pix_req_t           req;
    logic               pix_hit;
    logic               pix_we;
    logic [AW-1:0]      pix_addr;
    logic               clr_we;
    logic [AW-1:0]      clr_addr;

    logic               st_we;
    logic [AW-1:0]      st_addr;
    logic [COLOR_W-1:0] st_wdata;
    logic [COLOR_W-1:0] st_rdata;

    // canvas size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CANVAS_RESET;
            height_reg <= CANVAS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  width_reg  <= cfg_data;
                REG_CANVAS_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // saturate the canvas to the store size
    assign eff_w = (coord_t'(width_reg) > coord_t'(MAX_WIDTH)) ? coord_t'(MAX_WIDTH)
                                                               : coord_t'(width_reg);
    assign eff_h = (coord_t'(height_reg) > coord_t'(MAX_HEIGHT)) ? coord_t'(MAX_HEIGHT)
                                                                 : coord_t'(height_reg);

    rfb_seq #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rsp      (rsp),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .pix_hit  (pix_hit),
        .rd_data  (st_rdata),
        .req      (req),
        .clr_we   (clr_we),
        .clr_addr (clr_addr)
    );

    rfb_pix #(
        .XW (XW),
        .YW (YW)
    ) u_pix (
        .req   (req),
        .eff_w (eff_w),
        .eff_h (eff_h),
        .hit   (pix_hit),
        .we    (pix_we),
        .addr  (pix_addr)
    );

    // the clear sweep owns the port while it runs; otherwise the pixel unit
    assign st_we    = clr_we || pix_we;
    assign st_addr  = clr_we ? clr_addr : pix_addr;
    assign st_wdata = clr_we ? WHITE : req.color;

    rfb_store #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (st_wdata),
        .rdata (st_rdata)
    );

    `RFB_ASSERT_ALWAYS(a_reset_sweeps_first, clk, !rst_n |=> !cmd.ready, "command taken before reset sweep")
    `RFB_ASSERT(a_one_writer, clk, rst_n, !(clr_we && pix_we), "sweep and pixel write collide")

endmodule

### tb/rgb_framebuffer_rect_draw_test.sv
// ============================================================================
// rgb_framebuffer_rect_draw_test
// Self-checking bench for the RGB frame store and its drawing engine. A
// queue-fed driver offers command words. A shadow frame store, updated as each
// word is accepted, predicts the color word that comes back. A monitor
// compares each returned word with the oldest prediction. The run steps
// through canvas sizes from empty to saturated and idles both channels at
// random.
// ============================================================================
module rgb_framebuffer_rect_draw_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfb_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    localparam int STORE_WORDS = MAX_W * MAX_H;

    // opcodes the engine does not decode; they must come back as a zero word
    localparam logic [OPCODE_W-1:0] OP_FIRST_SPARE = OPCODE_W'(OP_FILL) + 3'd1;

    localparam int IDLE_PCT      = 25;      // chance in 100 that a side idles
    localparam int HOLD_AT       = 350;     // results seen before the long hold
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;      // quiet time after the last result
    localparam int MAX_REPORTS   = 40;
    localparam longint LIMIT_NS  = 64'd160_000_000;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [SIZE_W-1:0]   rect_width;
        logic [SIZE_W-1:0]   rect_height;
        logic [COLOR_W-1:0]  draw_color;
    } draw_cmd_t;

    // one outstanding command and the color word it must return
    typedef struct packed {
        draw_cmd_t          word;
        logic [COLOR_W-1:0] color;
    } due_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic      cmd_valid = 1'b0;
    draw_cmd_t cmd_word = '0;
    logic      rsp_ready = 1'b0;

    // steady: no idling on either side; rsp_hold: receiver holds off entirely
    logic steady = 1'b0;
    logic rsp_hold = 1'b0;

    draw_cmd_t cmd_backlog[$];
    due_t      pending_colors[$];

    // shadow of the frame store and of the canvas registers
    logic [COLOR_W-1:0] pixel_shadow [STORE_WORDS];
    logic [SIZE_W-1:0]  cur_width = CANVAS_RESET;
    logic [SIZE_W-1:0]  cur_height = CANVAS_RESET;

    int words_queued = 0;
    int words_taken = 0;
    int results_seen = 0;
    int error_count = 0;
    int phases_run = 0;
    int clears_left = 2;        // a clear sweeps the whole store; keep them rare
    int large_left = 10;        // rectangles drawn from the full size range
    int op_seen [2**OPCODE_W];

    rfb_cmd_if cmd_ch ();
    rfb_rsp_if rsp_ch ();

    assign cmd_ch.valid       = cmd_valid;
    assign cmd_ch.opcode      = cmd_word.opcode;
    assign cmd_ch.pos_x       = cmd_word.pos_x;
    assign cmd_ch.pos_y       = cmd_word.pos_y;
    assign cmd_ch.rect_width  = cmd_word.rect_width;
    assign cmd_ch.rect_height = cmd_word.rect_height;
    assign cmd_ch.draw_color  = cmd_word.draw_color;
    assign rsp_ch.ready       = rsp_ready;

    rgb_framebuffer_rect_draw DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow frame store
    // ------------------------------------------------------------------------

    // Registers above the maximum saturate; zero leaves an empty canvas.
    function automatic int active_width();
        return (int'(cur_width) > MAX_W) ? MAX_W : int'(cur_width);
    endfunction

    function automatic int active_height();
        return (int'(cur_height) > MAX_H) ? MAX_H : int'(cur_height);
    endfunction

    // Map a top-based pixel to its bottom-up store slot; false when clipped.
    function automatic bit locate(input int x, input int y, output int idx);
        int w;
        int h;
        int row;
        w = active_width();
        h = active_height();
        row = h - y - 1;
        idx = 0;
        if (x < 0 || x >= w || row < 0 || row >= h)
            return 1'b0;
        idx = row * MAX_W + x;
        return 1'b1;
    endfunction

    function automatic void paint(int x, int y, logic [COLOR_W-1:0] color);
        int idx;
        if (locate(x, y, idx))
            pixel_shadow[idx] = color;
    endfunction

    // Clear paints every slot, not just the visible canvas.
    function automatic void wipe_shadow();
        for (int i = 0; i < STORE_WORDS; i++)
            pixel_shadow[i] = WHITE;
    endfunction

    // Apply one command to the shadow and return the color word it yields.
    function automatic logic [COLOR_W-1:0] predict_read_color(draw_cmd_t c);
        int x;
        int y;
        int w;
        int h;
        int idx;
        bit fits;
        logic [COLOR_W-1:0] color;
        x = int'(c.pos_x);
        y = int'(c.pos_y);
        w = int'(c.rect_width);
        h = int'(c.rect_height);
        color = '0;
        // outline and fill draw only when the whole rectangle fits
        fits = (x + w <= active_width()) && (y + h <= active_height());
        case (c.opcode)
            OP_CLEAR:
                wipe_shadow();
            OP_POINT:
                paint(x, y, c.draw_color);
            OP_READ:
                if (locate(x, y, idx))
                    color = pixel_shadow[idx];
            OP_OUTLINE:
                if (fits)
                begin
                    // zero height puts the bottom edge on row y-1, zero width
                    // the right edge on column x-1; both still clip
                    for (int i = 0; i < w; i++)
                    begin
                        paint(x + i, y, c.draw_color);
                        paint(x + i, y + h - 1, c.draw_color);
                    end
                    for (int i = 0; i < h; i++)
                    begin
                        paint(x, y + i, c.draw_color);
                        paint(x + w - 1, y + i, c.draw_color);
                    end
                end
            OP_FILL:
                if (fits)
                begin
                    for (int i = 0; i < h; i++)
                        for (int j = 0; j < w; j++)
                            paint(x + j, y + i, c.draw_color);
                end
            default:
                ;
        endcase
        return color;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic draw_cmd_t make_word(logic [OPCODE_W-1:0] op, int x, int y,
                                            int w, int h, logic [COLOR_W-1:0] color);
        draw_cmd_t c;
        c.opcode      = op;
        c.pos_x       = POS_W'(x);
        c.pos_y       = POS_W'(y);
        c.rect_width  = SIZE_W'(w);
        c.rect_height = SIZE_W'(h);
        c.draw_color  = color;
        return c;
    endfunction

    function automatic void queue_word(draw_cmd_t c);
        cmd_backlog.insert(cmd_backlog.size(), c);
        words_queued++;
    endfunction

    // Random command shaped by the current canvas: positions mostly land on
    // the canvas and often in a small corner, so reads find drawn pixels, and
    // rectangles are mostly small and often trimmed so that they fit.
    function automatic draw_cmd_t random_word();
        draw_cmd_t c;
        int r;
        int aw;
        int ah;
        int span;
        int lim;
        int x;
        int y;
        int w;
        int h;
        aw = active_width();
        ah = active_height();
        r = $urandom_range(0, 999);
        if (r < 3)
        begin
            c.opcode = (clears_left > 0) ? OPCODE_W'(OP_CLEAR) : OPCODE_W'(OP_READ);
            if (clears_left > 0)
                clears_left--;
        end
        else if (r < 330)
            c.opcode = OP_POINT;
        else if (r < 680)
            c.opcode = OP_READ;
        else if (r < 830)
            c.opcode = OP_OUTLINE;
        else if (r < 970)
            c.opcode = OP_FILL;
        else
            c.opcode = OP_FIRST_SPARE + OPCODE_W'($urandom_range(0, 2));

        span = (aw > 0) ? aw : 1;
        if ($urandom_range(0, 1) == 0 && span > 32)
            span = 32;
        x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
        span = (ah > 0) ? ah : 1;
        if ($urandom_range(0, 1) == 0 && span > 32)
            span = 32;
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);

        r = $urandom_range(0, 99);
        if (r < 2 && large_left > 0)
        begin
            large_left--;
            lim = 2**SIZE_W - 1;
        end
        else if (r < 15)
            lim = 24;
        else
            lim = 8;
        w = $urandom_range(0, lim);
        h = $urandom_range(0, lim);
        // trim small rectangles to the canvas edge most of the time
        if (lim < 2**SIZE_W - 1 && $urandom_range(0, 9) < 6)
        begin
            if (aw >= x && w > aw - x)
                w = aw - x;
            if (ah >= y && h > ah - y)
                h = ah - y;
        end

        c.pos_x       = POS_W'(x);
        c.pos_y       = POS_W'(y);
        c.rect_width  = SIZE_W'(w);
        c.rect_height = SIZE_W'(h);
        c.draw_color  = COLOR_W'($urandom());
        return c;
    endfunction

    // Hold until every queued word is taken and every result is back, then
    // let the engine settle.
    task automatic drain_block();
        while (words_taken != words_queued || pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        // the write lands at this edge; mirror it in the shadow
        if (idx == REG_CANVAS_WIDTH)
            cur_width = SIZE_W'(value);
        else
            cur_height = SIZE_W'(value);
    endtask

    // Resize the canvas while idle, then queue a batch of random words.
    task automatic run_phase(int w, int h, int count, bit quiet);
        drain_block();
        write_reg(REG_CANVAS_WIDTH, w);
        write_reg(REG_CANVAS_HEIGHT, h);
        steady <= quiet;
        repeat (count) queue_word(random_word());
        phases_run++;
    endtask

    task automatic report_mismatch(string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Command driver: offer words from the backlog; keep valid high until the
    // word is taken and predict its result at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        due_t fresh;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && cmd_ch.ready)
            begin
                fresh.word  = cmd_word;
                fresh.color = predict_read_color(cmd_word);
                pending_colors.insert(pending_colors.size(), fresh);
                op_seen[cmd_word.opcode]++;
                words_taken++;
            end
            if (!cmd_valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() != 0
                    && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cmd_word  <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each returned word against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        due_t due;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ready)
            begin
                if (pending_colors.size() == 0)
                begin
                    report_mismatch($sformatf("color word %06h with no command outstanding",
                                              rsp_ch.read_color));
                end
                else
                begin
                    due = pending_colors.pop_front();
                    if (rsp_ch.read_color !== due.color)
                        report_mismatch($sformatf(
                            "op %0d x %0d y %0d w %0d h %0d: read_color %06h, want %06h",
                            due.word.opcode, due.word.pos_x, due.word.pos_y,
                            due.word.rect_width, due.word.rect_height,
                            rsp_ch.read_color, due.color));
                end
                results_seen++;
            end
            rsp_ready <= !rsp_hold && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Long receiver hold while the sender keeps offering: the engine finishes
    // its word, cannot hand the result over, and must stall the command side.
    initial
    begin : rsp_hold_off
        while (results_seen < HOLD_AT)
            @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int spare;
        spare = 0;
        for (int k = 0; k < 2**OPCODE_W; k++)
            op_seen[k] = 0;
        wipe_shadow();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset canvas size. The engine first sweeps the
        // store white, so these wait on the handshake until it is done.
        queue_word(make_word(OP_READ, 0, 0, 0, 0, 24'h000000));
        queue_word(make_word(OP_POINT, 0, 0, 0, 0, 24'h000000));
        queue_word(make_word(OP_READ, 0, 0, 0, 0, 24'hFFFFFF));
        queue_word(make_word(OP_POINT, 255, 255, 0, 0, 24'hFF0000));
        queue_word(make_word(OP_READ, 255, 255, 0, 0, 24'h000000));
        queue_word(make_word(OP_POINT, 255, 0, 0, 0, 24'h00FF00));
        queue_word(make_word(OP_READ, 255, 0, 0, 0, 24'h000000));
        // full-canvas fill, then a clear back to white
        queue_word(make_word(OP_FILL, 0, 0, 256, 256, 24'h123456));
        queue_word(make_word(OP_READ, 128, 77, 0, 0, 24'h000000));
        queue_word(make_word(OP_CLEAR, 0, 0, 0, 0, 24'h0000FF));
        queue_word(make_word(OP_READ, 255, 255, 0, 0, 24'h000000));
        // zero-height outline: bottom edge lands one row above the top edge
        queue_word(make_word(OP_OUTLINE, 10, 20, 5, 0, 24'hA5A5A5));
        queue_word(make_word(OP_READ, 12, 19, 0, 0, 24'h000000));
        queue_word(make_word(OP_READ, 12, 20, 0, 0, 24'h000000));
        // same at the top row, where the stray row is clipped
        queue_word(make_word(OP_OUTLINE, 0, 0, 3, 0, 24'hC0FFEE));
        queue_word(make_word(OP_READ, 1, 0, 0, 0, 24'h000000));
        // zero width at the left column: the stray column is clipped
        queue_word(make_word(OP_OUTLINE, 0, 5, 0, 4, 24'h5A5A5A));
        queue_word(make_word(OP_READ, 0, 6, 0, 0, 24'h000000));
        // rectangle that does not fit draws nothing
        queue_word(make_word(OP_OUTLINE, 40, 40, 256, 10, 24'h0F0F0F));
        queue_word(make_word(OP_FILL, 251, 0, 511, 511, 24'hF0F0F0));
        queue_word(make_word(OP_READ, 40, 40, 0, 0, 24'h000000));
        // largest outline, and a fill flush with the bottom-right corner
        queue_word(make_word(OP_OUTLINE, 0, 0, 256, 256, 24'h00FFFF));
        queue_word(make_word(OP_READ, 255, 100, 0, 0, 24'h000000));
        queue_word(make_word(OP_FILL, 250, 250, 6, 6, 24'hFFFF00));
        queue_word(make_word(OP_READ, 255, 255, 0, 0, 24'h000000));
        for (int k = 0; k < 3; k++)
            queue_word(make_word(OP_FIRST_SPARE + OPCODE_W'(k), 255, 255, 511, 511,
                                 24'hFFFFFF));
        phases_run++;

        // Random phases across canvas sizes: single pixel, empty, saturated
        // (run with no idling at all), one-row, one-column, two random, full.
        run_phase(1, 1, 100, 1'b0);
        run_phase(0, 0, 40, 1'b0);
        run_phase(511, 300, 150, 1'b1);
        run_phase(256, 1, 100, 1'b0);
        run_phase(1, 256, 100, 1'b0);
        run_phase($urandom_range(1, 256), $urandom_range(1, 256), 150, 1'b0);
        run_phase($urandom_range(1, 256), $urandom_range(1, 256), 150, 1'b0);
        run_phase(256, 256, 200, 1'b0);
        drain_block();

        for (int k = OP_FIRST_SPARE; k < 2**OPCODE_W; k++)
            spare += op_seen[k];
        $display({"summary: %0d words over %0d canvas sizes: %0d clear, %0d point, ",
                  "%0d read, %0d outline, %0d fill, %0d undecoded"},
                 words_taken, phases_run, op_seen[OP_CLEAR], op_seen[OP_POINT],
                 op_seen[OP_READ], op_seen[OP_OUTLINE], op_seen[OP_FILL], spare);
        $display("summary: %0d color words checked, %0d mismatches", results_seen, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: the slowest legal run is far below this.
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("[%0t] watchdog expired: %0d of %0d words taken, %0d results outstanding",
                 $time, words_taken, words_queued, pending_colors.size());
        $display("tb: failure");
        $finish;
    end

endmodule
